FILE: sv/smuf_pkg.sv
// Shared types, constants and helper functions for the stereo-mix / mu-law
// sample formatter. No dependencies.
package smuf_pkg;

  localparam int SAMPLE_W = 16;
  localparam int CODE_W   = 8;
  localparam int KIND_W   = 2;
  localparam int MODE_W   = 2;
  localparam int PCT_W    = 7;
  localparam int WEIGHT_W = 9;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = PCT_W;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [WEIGHT_W-1:0]        weight_t;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_MODE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIX_PERCENT = 1'd1;

  // Output modes; code 3 falls back to stereo crossmix
  localparam logic [MODE_W-1:0] MODE_STEREO    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_MONO_LIN  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_MONO_ULAW = 2'd2;

  localparam logic [KIND_W-1:0] KIND_STEREO = 2'd0;
  localparam logic [KIND_W-1:0] KIND_MONO   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ULAW   = 2'd2;

  localparam logic [PCT_W-1:0] PCT_RESET = 7'd30;

  // floor(pct * 256 / 100) == (pct * 5243) >> 11 for every 7-bit pct
  localparam int PCT_RECIP   = 5243;
  localparam int PCT_SHIFT   = 11;
  localparam int PCT_PROD_W  = PCT_W + 13;

  // Mu-law segment tables
  localparam int MAG_W = 14;
  localparam logic [MAG_W-1:0] SEG_TOP [8] = '{
    14'd32, 14'd96, 14'd224, 14'd480, 14'd992, 14'd2016, 14'd4064, 14'd8160
  };
  localparam logic [MAG_W-1:0] SEG_BASE [8] = '{
    14'd0, 14'd32, 14'd96, 14'd224, 14'd480, 14'd992, 14'd2016, 14'd4064
  };
  localparam logic [CODE_W-1:0] SEG_CODE [8] = '{
    8'hF0, 8'hE0, 8'hD0, 8'hC0, 8'hB0, 8'hA0, 8'h90, 8'h80
  };
  localparam logic [CODE_W-1:0] ULAW_OVER     = 8'h80;
  localparam logic [CODE_W-1:0] ULAW_MASK_POS = 8'hFF;
  localparam logic [CODE_W-1:0] ULAW_MASK_NEG = 8'h7F;

  // Crossmix weight from the percent setting
  function automatic weight_t pct_to_weight(input logic [PCT_W-1:0] pct);
    logic [PCT_PROD_W-1:0] prod;
    prod = PCT_PROD_W'(pct) * PCT_PROD_W'(PCT_RECIP);
    return prod[PCT_SHIFT +: WEIGHT_W];
  endfunction

  // Clip to 16 bits; bit 16 of the result flags a clip
  function automatic logic [SAMPLE_W:0] sat16(input logic signed [19:0] v);
    if (v > 20'sd32767)       return {1'b1, 16'h7FFF};
    else if (v < -20'sd32768) return {1'b1, 16'h8000};
    else                      return {1'b0, v[SAMPLE_W-1:0]};
  endfunction

  // Eight-segment mu-law approximation of a 13-bit signed value
  function automatic logic [CODE_W-1:0] mulaw_encode(input logic signed [12:0] v);
    logic signed [MAG_W-1:0] vx;
    logic [MAG_W-1:0]        m;
    logic [MAG_W-1:0]        q;
    logic [CODE_W-1:0]       mask;
    logic [CODE_W-1:0]       code;
    logic                    found;
    vx    = MAG_W'(v);
    m     = vx[MAG_W-1] ? $unsigned(-vx) : $unsigned(vx);
    mask  = vx[MAG_W-1] ? ULAW_MASK_NEG : ULAW_MASK_POS;
    code  = ULAW_OVER;
    found = 1'b0;
    for (int k = 0; k < 8; k++) begin
      if (!found && (m < SEG_TOP[k])) begin
        q     = (m - SEG_BASE[k]) >> (k + 1);
        code  = SEG_CODE[k] | {4'd0, 4'd15 - q[3:0]};
        found = 1'b1;
      end
    end
    return code & mask;
  endfunction

endpackage

FILE: sv/stereo_mix_ulaw_sample_formatter_core.sv
// Stereo crossmix / mono linear / mono mu-law sample formatter, top level.
// Depends on smuf_pkg for widths, codes, weight, clip and mu-law functions.
// The input stage registers the accepted pair; the result stage then registers
// the word and raises out_strobe. Throughput: one word per cycle; busy never
// rises and results cannot stall. Reset: synchronous, active low; mode returns
// to stereo crossmix, the crossmix setting to 30 percent, both stages empty.
module stereo_mix_ulaw_sample_formatter_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [smuf_pkg::SAMPLE_W-1:0] in_left_sample,
  input  logic signed [smuf_pkg::SAMPLE_W-1:0] in_right_sample,
  input  logic                                cfg_we,
  input  logic [smuf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [smuf_pkg::CFG_DATA_W-1:0]     cfg_data,
  output logic                                out_strobe,
  output logic signed [smuf_pkg::SAMPLE_W-1:0] out_first_word,
  output logic signed [smuf_pkg::SAMPLE_W-1:0] out_second_word,
  output logic [smuf_pkg::CODE_W-1:0]         out_ulaw_code,
  output logic [smuf_pkg::KIND_W-1:0]         out_result_kind,
  output logic                                out_saturated
);
  import smuf_pkg::*;

  // Configuration: hold the mode and the derived crossmix weight
  logic [MODE_W-1:0] mode_r;
  weight_t           pri_r;

  // Input stage
  logic    vld_r;
  sample_t l_r, r_r;

  // Result stage
  logic              strobe_r;
  sample_t           first_r, second_r;
  logic [CODE_W-1:0] code_r;
  logic [KIND_W-1:0] kind_r;
  logic              sat_r;

  sample_t           first_nxt, second_nxt;
  logic [CODE_W-1:0] code_nxt;
  logic [KIND_W-1:0] kind_nxt;
  logic              sat_nxt;

  // Crossmix datapath. With sec = 512 - pri:
  //   a = 512*r + pri*(l - r),  b = 512*l - pri*(l - r)
  // so one product serves both words.
  logic signed [16:0] diff;
  logic signed [26:0] prod;
  logic signed [27:0] a_sum, b_sum;
  logic signed [19:0] a_div, b_div;
  logic [SAMPLE_W:0]  a_sat, b_sat;

  // Mono datapath
  logic signed [16:0] mono_sum;
  logic [SAMPLE_W:0]  mono_sat;
  logic signed [16:0] ulaw_biased;
  logic signed [12:0] ulaw_in;

  assign busy = 1'b0;

  always_comb begin
    diff  = 17'(l_r) - 17'(r_r);
    prod  = 27'(diff) * $signed({18'd0, pri_r});
    a_sum = (28'(r_r) <<< 9) + 28'(prod);
    b_sum = (28'(l_r) <<< 9) - 28'(prod);
    // Divide by 256 rounding toward zero: bias negatives before the shift
    a_div = 20'((a_sum + (a_sum[27] ? 28'sd255 : 28'sd0)) >>> 8);
    b_div = 20'((b_sum + (b_sum[27] ? 28'sd255 : 28'sd0)) >>> 8);
    a_sat = sat16(a_div);
    b_sat = sat16(b_div);

    mono_sum    = 17'(l_r) + 17'(r_r);
    mono_sat    = sat16(20'(mono_sum));
    // Divide by 16 rounding toward zero
    ulaw_biased = mono_sum + (mono_sum[16] ? 17'sd15 : 17'sd0);
    ulaw_in     = 13'(ulaw_biased >>> 4);

    unique case (mode_r)
      MODE_MONO_LIN: begin
        first_nxt  = mono_sat[SAMPLE_W-1:0];
        second_nxt = '0;
        code_nxt   = '0;
        kind_nxt   = KIND_MONO;
        sat_nxt    = mono_sat[SAMPLE_W];
      end
      MODE_MONO_ULAW: begin
        first_nxt  = '0;
        second_nxt = '0;
        code_nxt   = mulaw_encode(ulaw_in);
        kind_nxt   = KIND_ULAW;
        sat_nxt    = 1'b0;
      end
      default: begin
        // Stereo crossmix, also taken for the unused mode code
        first_nxt  = a_sat[SAMPLE_W-1:0];
        second_nxt = b_sat[SAMPLE_W-1:0];
        code_nxt   = '0;
        kind_nxt   = KIND_STEREO;
        sat_nxt    = a_sat[SAMPLE_W] | b_sat[SAMPLE_W];
      end
    endcase
  end

  // Configuration writes; the weight is derived once here, not per word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_STEREO;
      pri_r  <= pct_to_weight(PCT_RESET);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_OUTPUT_MODE: mode_r <= cfg_data[MODE_W-1:0];
        CFG_MIX_PERCENT: pri_r  <= pct_to_weight(cfg_data[PCT_W-1:0]);
        default: ;
      endcase
    end
  end

  // Control: advance the valid flags every cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= 1'b0;
      strobe_r <= 1'b0;
    end else begin
      vld_r    <= start && !busy;
      strobe_r <= vld_r;
    end
  end

  // Payload: capture samples on accept, results in the following cycle
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      l_r <= in_left_sample;
      r_r <= in_right_sample;
    end
    if (vld_r) begin
      first_r  <= first_nxt;
      second_r <= second_nxt;
      code_r   <= code_nxt;
      kind_r   <= kind_nxt;
      sat_r    <= sat_nxt;
    end
  end

  assign out_strobe      = strobe_r;
  assign out_first_word  = first_r;
  assign out_second_word = second_r;
  assign out_ulaw_code   = code_r;
  assign out_result_kind = kind_r;
  assign out_saturated   = sat_r;

endmodule

FILE: sim/tb_stereo_mix_ulaw_sample_formatter_core.sv
// Self-checking testbench for the stereo crossmix / mono linear / mu-law sample formatter.
// Depends on smuf_pkg for widths, register indexes, mode and kind codes.
// Directed corner cases run first, then randomized phases under several sender gap levels.
`timescale 1ns / 100ps

module tb_stereo_mix_ulaw_sample_formatter_core;
  import smuf_pkg::*;

  // Mode code 3 has no package name; it must behave as stereo crossmix.
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam logic [PCT_W-1:0]  PERCENT_AT_RESET = 7'd30;

  // Own copy of the mu-law segment bounds, codes and overflow code.
  localparam int SEG_HI [8] = '{32, 96, 224, 480, 992, 2016, 4064, 8160};
  localparam int SEG_LO [8] = '{0, 32, 96, 224, 480, 992, 2016, 4064};
  localparam logic [7:0] SEG_ID [8] = '{
    8'hF0, 8'hE0, 8'hD0, 8'hC0, 8'hB0, 8'hA0, 8'h90, 8'h80
  };
  localparam logic [7:0] ULAW_CLIP_CODE = 8'h80;
  localparam logic [7:0] ULAW_NEG_MASK  = 8'h7F;
  localparam logic [7:0] ULAW_POS_MASK  = 8'hFF;

  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no word moved
  localparam int DRAIN_CYCLES   = 6;     // pipeline is 2 deep; leave margin
  localparam int PHASES         = 8;
  localparam int WORDS_PER_PHASE = 182;

  typedef struct packed {
    sample_t           first_word;
    sample_t           second_word;
    logic [CODE_W-1:0] ulaw_code;
    logic [KIND_W-1:0] result_kind;
    logic              saturated;
  } formatted_t;

  // Every input is driven to a known value from time zero.
  logic                  clk;
  logic                  rst_n           = 1'b0;
  logic                  start           = 1'b0;
  logic                  busy;
  sample_t               in_left_sample  = '0;
  sample_t               in_right_sample = '0;
  logic                  cfg_we          = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index       = '0;
  logic [CFG_DATA_W-1:0] cfg_data        = '0;
  logic                  out_strobe;
  sample_t               out_first_word;
  sample_t               out_second_word;
  logic [CODE_W-1:0]     out_ulaw_code;
  logic [KIND_W-1:0]     out_result_kind;
  logic                  out_saturated;

  // Shadow of the block's two registers, as seen by the predictor.
  logic [MODE_W-1:0] mode_q = MODE_STEREO;
  logic [PCT_W-1:0]  pct_q  = PERCENT_AT_RESET;

  formatted_t expected_words [$];
  int gap_pct      = 0;
  int fail_count   = 0;
  int words_sent   = 0;
  int words_seen   = 0;
  int reg_writes   = 0;
  int idle_cycles  = 0;

  stereo_mix_ulaw_sample_formatter_core u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_left_sample  (in_left_sample),
    .in_right_sample (in_right_sample),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .out_strobe      (out_strobe),
    .out_first_word  (out_first_word),
    .out_second_word (out_second_word),
    .out_ulaw_code   (out_ulaw_code),
    .out_result_kind (out_result_kind),
    .out_saturated   (out_saturated)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Clip a wide sum to 16 bits and flag the clip.
  function automatic sample_t clip16(input int v, inout bit clipped);
    if (v > 32767) begin
      clipped = 1'b1;
      return 16'sh7FFF;
    end
    if (v < -32768) begin
      clipped = 1'b1;
      return 16'sh8000;
    end
    return sample_t'(v);
  endfunction

  // Eight-segment mu-law approximation; negative values lose the top bit.
  function automatic logic [7:0] ulaw_of(input int v);
    int         m;
    int         q;
    logic [7:0] mask;
    m    = v;
    mask = ULAW_POS_MASK;
    if (m < 0) begin
      m    = -m;
      mask = ULAW_NEG_MASK;
    end
    for (int k = 0; k < 8; k++) begin
      if (m < SEG_HI[k]) begin
        q = (m - SEG_LO[k]) >>> (k + 1);
        return (SEG_ID[k] | 8'(15 - q)) & mask;
      end
    end
    return ULAW_CLIP_CODE & mask;
  endfunction

  // Expected output word for one sample pair under the given settings.
  function automatic formatted_t format_pair(input logic [MODE_W-1:0] mode,
                                             input logic [PCT_W-1:0] pct,
                                             input sample_t l, input sample_t r);
    formatted_t res;
    int         pri;
    int         sec;
    int         scaled;
    bit         clipped;
    res     = '0;
    clipped = 1'b0;
    case (mode)
      MODE_MONO_LIN: begin
        res.first_word  = clip16(int'(l) + int'(r), clipped);
        res.result_kind = KIND_MONO;
      end
      MODE_MONO_ULAW: begin
        // SV signed division truncates toward zero, as required
        scaled          = (int'(l) + int'(r)) / 16;
        res.ulaw_code   = ulaw_of(scaled);
        res.result_kind = KIND_ULAW;
      end
      default: begin
        // stereo crossmix; the unused mode code lands here too
        pri             = (int'(pct) * 256) / 100;
        sec             = 512 - pri;
        res.first_word  = clip16((int'(l) * pri + int'(r) * sec) / 256, clipped);
        res.second_word = clip16((int'(r) * pri + int'(l) * sec) / 256, clipped);
        res.result_kind = KIND_STEREO;
      end
    endcase
    res.saturated = clipped;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: sample everything right after the edge, so the values seen are
  // the ones the block saw at that edge.
  // ---------------------------------------------------------------------------

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : monitor
    formatted_t want;
    if (!rst_n) begin
      mode_q      = MODE_STEREO;
      pct_q       = PERCENT_AT_RESET;
      idle_cycles = 0;
    end else begin
      // Drain the oldest expectation for each strobed result word.
      if (out_strobe) begin
        if (expected_words.size() == 0) begin
          $error("result word arrived with no expectation waiting");
          fail_count++;
        end else begin
          want = expected_words.pop_front();
          check_field("first_word",  want.first_word,  out_first_word);
          check_field("second_word", want.second_word, out_second_word);
          check_field("ulaw_code",   want.ulaw_code,   out_ulaw_code);
          check_field("result_kind", want.result_kind, out_result_kind);
          check_field("saturated",   want.saturated,   out_saturated);
        end
        words_seen++;
      end
      // Predict on acceptance, with the settings in force before this edge.
      if (start && !busy) begin
        expected_words.push_back(format_pair(mode_q, pct_q, in_left_sample,
                                             in_right_sample));
        words_sent++;
      end
      if (cfg_we) begin
        if (cfg_index == CFG_OUTPUT_MODE) mode_q = cfg_data[MODE_W-1:0];
        else pct_q = cfg_data;
      end
      if (out_strobe || (start && !busy)) idle_cycles = 0;
      else idle_cycles++;
    end
  end

  // Abort if nothing moves for too long.
  initial begin
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Offer one sample pair; hold it until the block takes it.
  task automatic send_pair(input sample_t l, input sample_t r);
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start           <= 1'b1;
    in_left_sample  <= l;
    in_right_sample <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Drop start and wait until every expected word is back, plus margin.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write one register with the block idle.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we    <= 1'b0;
    reg_writes++;
  endtask

  // Mix of corner values, small magnitudes (to reach low mu-law segments)
  // and full-range random values.
  function automatic sample_t rand_sample();
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(3))
          0: return 16'sh8000;
          1: return 16'sh7FFF;
          2: return 16'sh0000;
          default: return -16'sh0001;
        endcase
      end
      1, 2: return sample_t'(int'($urandom_range(1023)) - 512);
      3: return sample_t'(int'($urandom_range(8191)) - 4096);
      default: return sample_t'($urandom);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Settings right after reset: stereo crossmix at 30 percent.
  task automatic test_reset_defaults();
    send_pair(16'sh4000, -16'sh2000);
    send_pair(-16'sh0001, 16'sh0000);  // negative blends truncate toward zero
  endtask

  // Crossmix at the weight extremes and above one hundred percent.
  task automatic test_stereo_crossmix();
    write_reg(CFG_OUTPUT_MODE, 7'(MODE_STEREO));
    write_reg(CFG_MIX_PERCENT, 7'd0);
    send_pair(16'sh7FFF, 16'sh7FFF);
    send_pair(16'sh8000, 16'sd100);
    write_reg(CFG_MIX_PERCENT, 7'd100);
    send_pair(16'sh7FFF, 16'sh8000);
    send_pair(16'sh8000, 16'sh8000);
    write_reg(CFG_MIX_PERCENT, 7'd127);
    send_pair(16'sh7FFF, 16'sh8000);
    send_pair(16'sd1000, -16'sd1);
  endtask

  // Mono sum, clipping at both ends.
  task automatic test_mono_linear();
    write_reg(CFG_OUTPUT_MODE, 7'(MODE_MONO_LIN));
    send_pair(16'sh7FFF, 16'sd1);
    send_pair(16'sh8000, -16'sd1);
    send_pair(16'sh7FFF, 16'sh8000);
    send_pair(16'sd12345, -16'sd345);
  endtask

  // Mu-law: zero, truncation toward zero, segment edges, both signs, extremes.
  task automatic test_mulaw();
    write_reg(CFG_OUTPUT_MODE, 7'(MODE_MONO_ULAW));
    send_pair(16'sd0, 16'sd0);
    send_pair(-16'sd17, 16'sd0);
    send_pair(16'sd496, 16'sd0);
    send_pair(16'sd512, 16'sd0);
    send_pair(-16'sd1535, -16'sd1);
    send_pair(16'sd32256, 16'sd0);
    send_pair(16'sh7FFF, 16'sh7FFF);
    send_pair(16'sh8000, 16'sh8000);
  endtask

  // Unused mode code behaves as crossmix; upper data bits are ignored.
  task automatic test_mode_three();
    write_reg(CFG_OUTPUT_MODE, {5'h1F, MODE_UNUSED});
    send_pair(16'sh7FFF, 16'sh7FFF);
    send_pair(-16'sd300, 16'sd7000);
  endtask

  // Random phases; the first four pin mode and percent extremes, the rest
  // draw them at random. Gap levels rotate, with gap-free stretches inside.
  task automatic test_random_phases();
    int phase_gap;
    logic [CFG_DATA_W-1:0] mode_data;
    logic [CFG_DATA_W-1:0] pct_data;
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin mode_data = 7'(MODE_STEREO);    pct_data = 7'd0;   end
        1: begin mode_data = 7'(MODE_MONO_LIN);  pct_data = 7'd127; end
        2: begin mode_data = 7'(MODE_MONO_ULAW); pct_data = 7'd100; end
        3: begin mode_data = 7'(MODE_UNUSED);    pct_data = 7'd1;   end
        default: begin
          mode_data = 7'($urandom);
          pct_data  = 7'($urandom_range(127));
        end
      endcase
      write_reg(CFG_MIX_PERCENT, pct_data);
      write_reg(CFG_OUTPUT_MODE, mode_data);
      case (p % 3)
        0: phase_gap = 0;
        1: phase_gap = 49;
        default: phase_gap = 26;
      endcase
      for (int i = 0; i < WORDS_PER_PHASE; i++) begin
        gap_pct = ((i / 30) % 3 == 2) ? 0 : phase_gap;
        send_pair(rand_sample(), rand_sample());
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    gap_pct = 26;
    test_reset_defaults();
    test_stereo_crossmix();
    test_mono_linear();
    test_mulaw();
    test_mode_three();
    test_random_phases();
    drain();
    $display("Covered %0d sample pairs and %0d result words over %0d register writes,",
             words_sent, words_seen, reg_writes);
    $display("all four mode codes, percent 0..127, sender gaps of 0, 26 and 49 percent.");
    if (fail_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
